// File: rtl/lsac_pkg.sv
// ----------------------------------------------------------------------------
// lsac_pkg
// Shared codes and fixed widths for the LRU cache directory model.
// ----------------------------------------------------------------------------
package lsac_pkg;

  localparam int ADDR_W  = 64;
  localparam int TAG_W   = 62;  // set and offset take at least two bits
  localparam int CNT_W   = 32;
  localparam int FUNC_W  = 2;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_STORE  = 2'd1,
    FUNC_MODIFY = 2'd2,
    FUNC_OTHER  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_SET_BITS   = 2'd0,
    REG_WAYS       = 2'd1,
    REG_BLOCK_BITS = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

endpackage

// File: rtl/lsac_queue.sv
// ----------------------------------------------------------------------------
// lsac_queue
// Two-entry lookup queue between the front and back ends.
// ----------------------------------------------------------------------------
module lsac_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] entries_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push && push_ready) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && pop_valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'((push && push_ready) ? 1 : 0) - 2'((pop && pop_valid) ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/lsac_front.sv
// ----------------------------------------------------------------------------
// lsac_front
// Config registers, request intake, time stamp, set/tag split and
// expansion of a modify into two lookups.
// ----------------------------------------------------------------------------
module lsac_front #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int STAMP_WIDTH  = 32,
  parameter int SB_W         = $clog2(MAX_SET_BITS + 1),
  parameter int NW_W         = $clog2(MAX_WAYS + 1),
  parameter int ENT_W        = 1 + NW_W + MAX_SET_BITS + lsac_pkg::TAG_W + STAMP_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsac_pkg::PADDR_W-1:0] paddr,
  input  logic [lsac_pkg::PDATA_W-1:0] pwdata,
  output logic [lsac_pkg::PDATA_W-1:0] prdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lsac_pkg::FUNC_W-1:0]  in_func,
  input  logic [lsac_pkg::ADDR_W-1:0]  in_address,
  input  logic                         clearing,
  output logic                         q_push,
  output logic [ENT_W-1:0]             q_data,
  input  logic                         q_ready
);

  logic [2:0]                  set_bits_r;
  logic [3:0]                  ways_r;
  logic [5:0]                  block_bits_r;
  logic [STAMP_WIDTH-1:0]      access_time_r;
  logic                        hold_valid_r;
  lsac_pkg::func_t             hold_func_r;
  logic [lsac_pkg::ADDR_W-1:0] hold_addr_r;
  logic [STAMP_WIDTH-1:0]      hold_stamp_r;
  logic                        second_r;

  lsac_pkg::reg_idx_t          reg_idx;
  logic                        in_fire;
  logic                        cfg_we;
  logic [SB_W-1:0]             sb;
  logic [NW_W-1:0]             nw;
  logic [5:0]                  bb;
  logic [MAX_SET_BITS-1:0]     set_idx;
  logic [lsac_pkg::TAG_W-1:0]  tag;
  logic                        push_last;

  assign reg_idx  = lsac_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_we   = psel && penable && pwrite;
  assign in_ready = !hold_valid_r && !clearing;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    unique case (reg_idx)
      lsac_pkg::REG_SET_BITS:   prdata = 32'(set_bits_r);
      lsac_pkg::REG_WAYS:       prdata = 32'(ways_r);
      lsac_pkg::REG_BLOCK_BITS: prdata = 32'(block_bits_r);
      default:                  prdata = '0;
    endcase
  end

  // clamp the geometry to its legal range
  always_comb begin
    if (set_bits_r == 3'd0) begin
      sb = SB_W'(1);
    end else if (int'(set_bits_r) > MAX_SET_BITS) begin
      sb = SB_W'(MAX_SET_BITS);
    end else begin
      sb = SB_W'(set_bits_r);
    end
    if (ways_r == 4'd0) begin
      nw = NW_W'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      nw = NW_W'(MAX_WAYS);
    end else begin
      nw = NW_W'(ways_r);
    end
    if (block_bits_r == 6'd0) begin
      bb = 6'd1;
    end else if (block_bits_r > 6'd32) begin
      bb = 6'd32;
    end else begin
      bb = block_bits_r;
    end
  end

  assign set_idx = MAX_SET_BITS'((hold_addr_r >> bb) & ((64'd1 << sb) - 64'd1));
  assign tag     = lsac_pkg::TAG_W'(hold_addr_r >> (7'(sb) + 7'(bb)));

  assign push_last = !(hold_func_r == lsac_pkg::FUNC_MODIFY && !second_r);
  assign q_push    = hold_valid_r;
  assign q_data    = {push_last, nw, set_idx, tag, hold_stamp_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= 3'd1;
      ways_r        <= 4'd1;
      block_bits_r  <= 6'd1;
      access_time_r <= '0;
      hold_valid_r  <= 1'b0;
      second_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx)
          lsac_pkg::REG_SET_BITS:   set_bits_r   <= pwdata[2:0];
          lsac_pkg::REG_WAYS:       ways_r       <= pwdata[3:0];
          lsac_pkg::REG_BLOCK_BITS: block_bits_r <= pwdata[5:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        if (access_time_r != '1) begin
          access_time_r <= access_time_r + STAMP_WIDTH'(1);
        end
        hold_valid_r <= (lsac_pkg::func_t'(in_func) != lsac_pkg::FUNC_OTHER);
        second_r     <= 1'b0;
      end else if (hold_valid_r && q_ready) begin
        if (push_last) begin
          hold_valid_r <= 1'b0;
        end else begin
          second_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_func_r  <= lsac_pkg::func_t'(in_func);
      hold_addr_r  <= in_address;
      hold_stamp_r <= access_time_r;
    end
  end

endmodule

// File: rtl/lsac_back.sv
// ----------------------------------------------------------------------------
// lsac_back
// Directory lookup engine: set read, way compare and LRU pick, row write,
// running totals and the result register.
// ----------------------------------------------------------------------------
module lsac_back #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int STAMP_WIDTH  = 32,
  parameter int NW_W         = $clog2(MAX_WAYS + 1),
  parameter int ENT_W        = 1 + NW_W + MAX_SET_BITS + lsac_pkg::TAG_W + STAMP_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  output logic                       clearing,
  input  logic                       q_valid,
  input  logic [ENT_W-1:0]           q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic                       out_miss,
  output logic                       out_eviction,
  output logic [lsac_pkg::CNT_W-1:0] out_hit_count,
  output logic [lsac_pkg::CNT_W-1:0] out_miss_count,
  output logic [lsac_pkg::CNT_W-1:0] out_eviction_count,
  output logic                       out_last
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TAG_W    = lsac_pkg::TAG_W;
  localparam int CNT_W    = lsac_pkg::CNT_W;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EVAL, S_WRITE} state_t;

  typedef logic [MAX_WAYS-1:0]                   vrow_t;
  typedef logic [MAX_WAYS-1:0][TAG_W-1:0]        trow_t;
  typedef logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0]  srow_t;

  vrow_t valid_mem [NUM_SETS];
  trow_t tag_mem   [NUM_SETS];
  srow_t stamp_mem [NUM_SETS];

  state_t                  state_r;
  logic [MAX_SET_BITS-1:0] clr_idx_r;
  logic [ENT_W-1:0]        cur_r;
  vrow_t                   rd_v_r;
  trow_t                   rd_t_r;
  srow_t                   rd_s_r;
  logic [WAY_W-1:0]        pick_r;
  logic                    hit_r;
  logic                    evict_r;
  logic                    out_valid_r;
  logic                    out_hit_r;
  logic                    out_miss_r;
  logic                    out_eviction_r;
  logic                    out_last_r;
  logic [CNT_W-1:0]        hit_cnt_r;
  logic [CNT_W-1:0]        miss_cnt_r;
  logic [CNT_W-1:0]        evict_cnt_r;

  logic [STAMP_WIDTH-1:0]  cur_stamp;
  logic [TAG_W-1:0]        cur_tag;
  logic [MAX_SET_BITS-1:0] cur_set;
  logic [NW_W-1:0]         cur_nw;
  logic                    cur_last;
  logic [MAX_SET_BITS-1:0] q_set;

  logic                    hit_f;
  logic                    inv_f;
  logic [WAY_W-1:0]        hit_way;
  logic [WAY_W-1:0]        inv_way;
  logic [WAY_W-1:0]        lru_way;
  logic [STAMP_WIDTH-1:0]  min_s;

  logic                    out_free;
  logic                    do_write;
  vrow_t                   wr_v;
  trow_t                   wr_t;
  srow_t                   wr_s;

  assign {cur_last, cur_nw, cur_set, cur_tag, cur_stamp} = cur_r;
  assign q_set    = q_data[TAG_W + STAMP_WIDTH +: MAX_SET_BITS];
  assign clearing = (state_r == S_CLEAR);
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign out_free = !out_valid_r || out_ready;
  assign do_write = (state_r == S_WRITE) && out_free;

  // way search: first matching valid way, first free way, oldest stamp
  always_comb begin
    hit_f   = 1'b0;
    inv_f   = 1'b0;
    hit_way = '0;
    inv_way = '0;
    lru_way = '0;
    min_s   = rd_s_r[0];
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w < int'(cur_nw)) begin
        if (!hit_f && rd_v_r[w] && rd_t_r[w] == cur_tag) begin
          hit_f   = 1'b1;
          hit_way = WAY_W'(w);
        end
        if (!inv_f && !rd_v_r[w]) begin
          inv_f   = 1'b1;
          inv_way = WAY_W'(w);
        end
        if (rd_s_r[w] < min_s) begin
          min_s   = rd_s_r[w];
          lru_way = WAY_W'(w);
        end
      end
    end
  end

  always_comb begin
    wr_v = rd_v_r;
    wr_t = rd_t_r;
    wr_s = rd_s_r;
    wr_v[pick_r] = 1'b1;
    wr_t[pick_r] = cur_tag;
    wr_s[pick_r] = cur_stamp;
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      valid_mem[clr_idx_r] <= '0;
    end else if (do_write) begin
      valid_mem[cur_set] <= wr_v;
    end
    if (do_write) begin
      tag_mem[cur_set]   <= wr_t;
      stamp_mem[cur_set] <= wr_s;
    end
    if (q_pop) begin
      rd_v_r <= valid_mem[q_set];
      rd_t_r <= tag_mem[q_set];
      rd_s_r <= stamp_mem[q_set];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + MAX_SET_BITS'(1);
          if (clr_idx_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          hit_r   <= hit_f;
          evict_r <= !hit_f && !inv_f;
          pick_r  <= hit_f ? hit_way : (inv_f ? inv_way : lru_way);
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_hit_r      <= hit_r;
            out_miss_r     <= !hit_r;
            out_eviction_r <= evict_r;
            out_last_r     <= cur_last;
            if (hit_r && hit_cnt_r != '1) begin
              hit_cnt_r <= hit_cnt_r + CNT_W'(1);
            end
            if (!hit_r && miss_cnt_r != '1) begin
              miss_cnt_r <= miss_cnt_r + CNT_W'(1);
            end
            if (evict_r && evict_cnt_r != '1) begin
              evict_cnt_r <= evict_cnt_r + CNT_W'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_miss           = out_miss_r;
  assign out_eviction       = out_eviction_r;
  assign out_last           = out_last_r;
  assign out_hit_count      = hit_cnt_r;
  assign out_miss_count     = miss_cnt_r;
  assign out_eviction_count = evict_cnt_r;

  a_hit_xor_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_hit_r != out_miss_r))
    else $error("result is both or neither hit and miss");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eviction_r) |-> out_miss_r)
    else $error("eviction reported on a hit");

  a_no_lookup_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !q_valid)
    else $error("lookup queued during directory clear");

  a_write_updates_result: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |=> out_valid_r)
    else $error("row written without a result");

endmodule

// File: rtl/lru_set_assoc_cache_sim_unit.sv
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_sim_unit
// Set-associative cache directory with LRU replacement and hit/miss totals.
// ----------------------------------------------------------------------------
// Path: a request waits in the front end's hold register; each lookup then goes
// through the queue and the back end's set read, way compare and row write, which
// loads the result register once that is free. A modify queues two lookups, an
// other-kind none; the back end finishes one lookup before it takes the next.
// Reset: synchronous; after reset the valid bits are swept one set per cycle
// (all 2**MAX_SET_BITS sets, 64 by default) and no request is taken meanwhile.
module lru_set_assoc_cache_sim_unit #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int STAMP_WIDTH  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsac_pkg::PADDR_W-1:0] paddr,
  input  logic [lsac_pkg::PDATA_W-1:0] pwdata,
  output logic [lsac_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lsac_pkg::FUNC_W-1:0]  in_func,
  input  logic [lsac_pkg::ADDR_W-1:0]  in_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic                         out_miss,
  output logic                         out_eviction,
  output logic [lsac_pkg::CNT_W-1:0]   out_hit_count,
  output logic [lsac_pkg::CNT_W-1:0]   out_miss_count,
  output logic [lsac_pkg::CNT_W-1:0]   out_eviction_count,
  output logic                         out_last
);

  localparam int NW_W  = $clog2(MAX_WAYS + 1);
  localparam int ENT_W = 1 + NW_W + MAX_SET_BITS + lsac_pkg::TAG_W + STAMP_WIDTH;

  logic             clearing;
  logic             push;
  logic             push_ready;
  logic [ENT_W-1:0] push_data;
  logic             pop;
  logic             pop_valid;
  logic [ENT_W-1:0] pop_data;

  assign pready = 1'b1;

  lsac_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .STAMP_WIDTH  (STAMP_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_address (in_address),
    .clearing   (clearing),
    .q_push     (push),
    .q_data     (push_data),
    .q_ready    (push_ready)
  );

  lsac_queue #(
    .W (ENT_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  lsac_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .STAMP_WIDTH  (STAMP_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .clearing           (clearing),
    .q_valid            (pop_valid),
    .q_data             (pop_data),
    .q_pop              (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_miss           (out_miss),
    .out_eviction       (out_eviction),
    .out_hit_count      (out_hit_count),
    .out_miss_count     (out_miss_count),
    .out_eviction_count (out_eviction_count),
    .out_last           (out_last)
  );

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the LRU cache directory: directed requests, then random traces over
// several geometries, with each lookup result compared against an in-bench
// directory model.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS_MAX  = 6;
  localparam int WAYS_MAX  = 8;
  localparam int LINES     = (1 << SETS_MAX) * WAYS_MAX;
  localparam int LIMIT     = 400000;
  localparam int PHASE_N   = 130;
  localparam int DRAIN_CYC = 12;

  typedef struct {
    logic                       hit;
    logic                       miss;
    logic                       evict;
    logic [lsac_pkg::CNT_W-1:0] hits;
    logic [lsac_pkg::CNT_W-1:0] misses;
    logic [lsac_pkg::CNT_W-1:0] evicts;
    logic                       last;
  } lookup_res_t;

  typedef struct {
    lsac_pkg::func_t             func;
    logic [lsac_pkg::ADDR_W-1:0] addr;
    bit                          typed;
    logic                        hit;
    logic                        miss;
    logic                        evict;
  } dir_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [lsac_pkg::PADDR_W-1:0] paddr = '0;
  logic [lsac_pkg::PDATA_W-1:0] pwdata = '0;
  logic [lsac_pkg::PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic [lsac_pkg::FUNC_W-1:0] in_func = '0;
  logic [lsac_pkg::ADDR_W-1:0] in_address = '0;
  logic out_valid;
  logic out_ready = 0;
  logic out_hit, out_miss, out_eviction, out_last;
  logic [lsac_pkg::CNT_W-1:0] out_hit_count, out_miss_count, out_eviction_count;

  lru_set_assoc_cache_sim_unit dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_address(in_address),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_miss(out_miss), .out_eviction(out_eviction),
    .out_hit_count(out_hit_count), .out_miss_count(out_miss_count),
    .out_eviction_count(out_eviction_count), .out_last(out_last)
  );

  always #1 clk = ~clk;

  // directory shadow
  bit                          line_vld [LINES];
  logic [lsac_pkg::ADDR_W-1:0] line_tg  [LINES];
  logic [31:0]                 line_stp [LINES];
  logic [31:0]                 now_stamp;
  logic [lsac_pkg::CNT_W-1:0]  hit_tot, miss_tot, evict_tot;
  logic [2:0]                  cfg_sets;
  logic [3:0]                  cfg_ways;
  logic [5:0]                  cfg_block;

  lookup_res_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 0;
  bit calm = 0;

  function automatic logic [lsac_pkg::CNT_W-1:0] bump(logic [lsac_pkg::CNT_W-1:0] v);
    return (v == '1) ? v : v + 1;
  endfunction

  function automatic lookup_res_t lookup_line(logic [lsac_pkg::ADDR_W-1:0] addr,
                                              logic is_last);
    int sb, nw, bb, base, pick;
    logic [lsac_pkg::ADDR_W-1:0] set_no, tg;
    lookup_res_t r;
    sb = (cfg_sets == 0) ? 1 : (cfg_sets > SETS_MAX ? SETS_MAX : cfg_sets);
    nw = (cfg_ways == 0) ? 1 : (cfg_ways > WAYS_MAX ? WAYS_MAX : cfg_ways);
    bb = (cfg_block == 0) ? 1 : (cfg_block > 32 ? 32 : cfg_block);
    set_no = (addr >> bb) & ((64'd1 << sb) - 1);
    tg = addr >> (sb + bb);
    base = int'(set_no) * WAYS_MAX;
    r.hit = 0;
    r.evict = 0;
    for (int w = 0; w < nw; w++) begin
      if (!r.hit && line_vld[base+w] && line_tg[base+w] == tg) begin
        r.hit = 1;
        line_stp[base+w] = now_stamp;
      end
    end
    if (r.hit) begin
      hit_tot = bump(hit_tot);
    end else begin
      miss_tot = bump(miss_tot);
      pick = nw;
      for (int w = nw - 1; w >= 0; w--)
        if (!line_vld[base+w]) pick = w;
      if (pick == nw) begin
        r.evict = 1;
        evict_tot = bump(evict_tot);
        pick = 0;
        for (int w = 1; w < nw; w++)
          if (line_stp[base+w] < line_stp[base+pick]) pick = w;
      end
      line_vld[base+pick] = 1;
      line_tg[base+pick] = tg;
      line_stp[base+pick] = now_stamp;
    end
    r.miss = ~r.hit;
    r.hits = hit_tot;
    r.misses = miss_tot;
    r.evicts = evict_tot;
    r.last = is_last;
    return r;
  endfunction

  // returns the number of lookups queued for this request
  function automatic int predict_request(lsac_pkg::func_t f,
                                         logic [lsac_pkg::ADDR_W-1:0] addr);
    int n;
    n = 0;
    if (f == lsac_pkg::FUNC_LOAD || f == lsac_pkg::FUNC_STORE) begin
      pending_results.push_back(lookup_line(addr, 1'b1));
      n = 1;
    end else if (f == lsac_pkg::FUNC_MODIFY) begin
      pending_results.push_back(lookup_line(addr, 1'b0));
      pending_results.push_back(lookup_line(addr, 1'b1));
      n = 2;
    end
    if (now_stamp != '1) now_stamp = now_stamp + 1;
    return n;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    lookup_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_hit !== e.hit) report("hit", out_hit, e.hit);
        if (out_miss !== e.miss) report("miss", out_miss, e.miss);
        if (out_eviction !== e.evict) report("eviction", out_eviction, e.evict);
        if (out_hit_count !== e.hits) report("hit_count", out_hit_count, e.hits);
        if (out_miss_count !== e.misses) report("miss_count", out_miss_count, e.misses);
        if (out_eviction_count !== e.evicts)
          report("eviction_count", out_eviction_count, e.evicts);
        if (out_last !== e.last) report("last", out_last, e.last);
      end
    end
  end

  // result side: random stalls, calm stretches, one long hold-off
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        hold_off = 0;
        out_ready <= 0;
        repeat (400) @(posedge clk);
      end else begin
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
          out_ready <= 0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_request(lsac_pkg::func_t f, logic [lsac_pkg::ADDR_W-1:0] addr,
                              output int n);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_func <= f;
    in_address <= addr;
    do @(posedge clk); while (!(in_valid && in_ready));
    n = predict_request(f, addr);
  endtask

  task automatic write_reg(lsac_pkg::reg_idx_t idx, logic [lsac_pkg::PDATA_W-1:0] val);
    in_valid <= 0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      lsac_pkg::REG_SET_BITS:   cfg_sets = val[2:0];
      lsac_pkg::REG_WAYS:       cfg_ways = val[3:0];
      lsac_pkg::REG_BLOCK_BITS: cfg_block = val[5:0];
      default: ;
    endcase
  endtask

  dir_row_t directed[$] = '{
    '{lsac_pkg::FUNC_LOAD,   64'h0,                   1, 0, 1, 0},
    '{lsac_pkg::FUNC_STORE,  64'h1,                   1, 1, 0, 0},
    '{lsac_pkg::FUNC_LOAD,   64'h4,                   1, 0, 1, 1},
    '{lsac_pkg::FUNC_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 1, 0},
    '{lsac_pkg::FUNC_OTHER,  64'h0,                   0, 0, 0, 0},
    '{lsac_pkg::FUNC_LOAD,   64'h0,                   1, 0, 1, 1},
    '{lsac_pkg::FUNC_LOAD,   64'h8000_0000_0000_0002, 1, 0, 1, 1},
    '{lsac_pkg::FUNC_MODIFY, 64'h2,                   1, 0, 1, 1},
    '{lsac_pkg::FUNC_STORE,  64'h3,                   0, 0, 0, 0},
    '{lsac_pkg::FUNC_OTHER,  64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0},
    '{lsac_pkg::FUNC_MODIFY, 64'h0,                   0, 0, 0, 0},
    '{lsac_pkg::FUNC_LOAD,   64'h5555_5555_5555_5555, 0, 0, 0, 0},
    '{lsac_pkg::FUNC_STORE,  64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 0}
  };

  initial begin
    int n, first_idx;
    logic [lsac_pkg::ADDR_W-1:0] pool[24];
    logic [lsac_pkg::ADDR_W-1:0] a;
    lsac_pkg::func_t f;
    logic [2:0] geo_sets[7]  = '{3'd6, 3'd0, 3'd7, 3'd2, 3'd3, 3'd1, 3'd4};
    logic [3:0] geo_ways[7]  = '{4'd8, 4'd0, 4'd15, 4'd4, 4'd2, 4'd8, 4'd3};
    logic [5:0] geo_block[7] = '{6'd32, 6'd0, 6'd63, 6'd3, 6'd5, 6'd1, 6'd12};
    now_stamp = 0;
    hit_tot = 0;
    miss_tot = 0;
    evict_tot = 0;
    cfg_sets = 1;
    cfg_ways = 1;
    cfg_block = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    foreach (directed[i]) begin
      send_request(directed[i].func, directed[i].addr, n);
      first_idx = pending_results.size() - n;
      if (directed[i].typed && n > 0) begin
        // typed flags override the model's first lookup of the row
        pending_results[first_idx].hit = directed[i].hit;
        pending_results[first_idx].miss = directed[i].miss;
        pending_results[first_idx].evict = directed[i].evict;
      end
    end

    write_reg(lsac_pkg::REG_NONE, 32'hFFFF_FFFF);
    for (int p = 0; p < 7; p++) begin
      write_reg(lsac_pkg::REG_SET_BITS, {$urandom} & 32'hFFFF_FFF8 | geo_sets[p]);
      write_reg(lsac_pkg::REG_WAYS, geo_ways[p]);
      write_reg(lsac_pkg::REG_BLOCK_BITS, geo_block[p]);
      foreach (pool[k])
        pool[k] = (k < 12) ? 64'($urandom_range(0, 4095)) << $urandom_range(0, 40)
                           : {$urandom, $urandom};
      calm = (p == 3);
      if (p == 2) begin
        hold_off = 1;
        calm = 1;
      end
      for (int k = 0; k < PHASE_N; k++) begin
        if (k == 40) calm = 0;
        a = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                        : pool[$urandom_range(0, 23)] ^ 64'($urandom_range(0, 1));
        f = lsac_pkg::func_t'($urandom_range(0, 3));
        send_request(f, a, n);
      end
    end
    in_valid <= 0;
    calm = 0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
rtl/lsac_pkg.sv
rtl/lsac_queue.sv
rtl/lsac_front.sv
rtl/lsac_back.sv
rtl/lru_set_assoc_cache_sim_unit.sv
tb/sv/tb_top.sv
